/* sv/lrw_pkg.sv */
// ----------------------------------------------------------------------------
// lrw_pkg
// shared types and constants of the linear remap unit with range wrapping
// ----------------------------------------------------------------------------
package lrw_pkg;

  localparam int unsigned QW       = 17;  // unsigned q0.16 value, one bit of headroom
  localparam int unsigned CW       = 24;  // signed q8.16 coefficient
  localparam int unsigned TDATA_W  = 24;  // qw rounded up to whole bytes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  localparam logic [QW-1:0] ONE_Q16 = QW'(65536);

  // operating modes
  localparam logic [2:0] MODE_IDENTITY = 3'd0;
  localparam logic [2:0] MODE_UNDEF    = 3'd1;
  localparam logic [2:0] MODE_CLAMP    = 3'd2;
  localparam logic [2:0] MODE_WRAP     = 3'd3;
  localparam logic [2:0] MODE_FOLD     = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHRINK    = 3'd5;

  typedef struct packed {
    logic [2:0]           mode;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] offset_b;
    logic [QW-1:0]        range_min;
    logic [QW-1:0]        range_max;
    logic                 shrink;
  } cfg_t;

  // clip a raw 17 bit word to 1.0
  function automatic logic [QW-1:0] sat_one(input logic [QW-1:0] v);
    sat_one = (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

/* sv/lrw_linear.sv */
// ----------------------------------------------------------------------------
// lrw_linear
// first two pipeline stages: slope product, then offset and range handling
// ----------------------------------------------------------------------------
module lrw_linear (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  lrw_pkg::cfg_t         cfg_i,
  input  logic                  valid_i,
  input  logic [lrw_pkg::QW-1:0] progress_i,
  input  logic                  undef_i,
  output logic                  valid_o,
  output logic [lrw_pkg::QW-1:0] value_o,
  output logic                  undef_o
);
  import lrw_pkg::*;

  localparam int unsigned PW = CW + QW + 1;  // a * x product
  localparam int unsigned RW = PW - 16 + 1;  // floor(a*x) + b with carry

  // stage 1
  logic                 valid1_q;
  logic                 undef1_q;
  logic [QW-1:0]        x1_q;
  logic [QW-1:0]        x_sat;
  logic signed [PW-1:0] prod_d, prod_q;

  // stage 2
  logic                 valid2_q;
  logic                 undef2_d, undef2_q;
  logic [QW-1:0]        v2_d, v2_q;
  logic signed [RW-1:0] r;
  logic [15:0]          frac;
  logic                 in_range;

  assign x_sat  = sat_one(progress_i);
  // both operands signed, so they are sign extended to the product width
  assign prod_d = $signed(cfg_i.coef_a) * $signed({1'b0, x_sat});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      undef1_q <= undef_i;
      x1_q     <= x_sat;
      prod_q   <= prod_d;
      undef2_q <= undef2_d;
      v2_q     <= v2_d;
    end
  end

  // truncating the low 16 bits is a floor toward minus infinity
  assign r = $signed({prod_q[PW-1], prod_q[PW-1:16]})
           + $signed({{(RW-CW){cfg_i.offset_b[CW-1]}}, cfg_i.offset_b});
  assign in_range = !r[RW-1] && (r[RW-2:0] <= (RW-1)'(ONE_Q16));
  assign frac     = r[15:0];

  always_comb begin
    undef2_d = undef1_q;
    v2_d     = '0;
    if (!undef1_q) begin
      if (cfg_i.mode == MODE_IDENTITY) begin
        v2_d = x1_q;
      end else if (in_range) begin
        v2_d = r[QW-1:0];
      end else begin
        unique case (cfg_i.mode)
          MODE_UNDEF: undef2_d = 1'b1;
          MODE_CLAMP: v2_d     = r[RW-1] ? '0 : ONE_Q16;
          MODE_WRAP:  v2_d     = {1'b0, frac};
          default: begin
            // fold: odd floor mirrors the fraction
            v2_d = r[16] ? (ONE_Q16 - {1'b0, frac}) : {1'b0, frac};
          end
        endcase
      end
    end
  end

  assign valid_o = valid2_q;
  assign value_o = v2_q;
  assign undef_o = undef2_q;

endmodule

/* sv/linear_remap_with_wrap_unit.sv */
// ----------------------------------------------------------------------------
// linear_remap_with_wrap_unit
// progress remapper: a*x+b with out-of-range handling, then min/max stage
// ----------------------------------------------------------------------------
// channel   direction  payload
// s_axis    in         tdata: progress[16:0], tuser: progress_undefined
// m_axis    out        tdata: mapped[16:0],   tuser: mapped_undefined
// cfg       in         cfg_index_i selects register, cfg_data_i its value
//
// four register stages: slope product, offset and wrap/fold, span product,
// final add or clamp into the output register. one transaction is accepted
// every cycle while the pipe advances. all stages advance together; while the
// output register holds an untaken result the whole pipe holds and
// s_axis_tready is low. reset clears the valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module linear_remap_with_wrap_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lrw_pkg::TDATA_W-1:0]    s_axis_tdata,  // progress[16:0], zero pad
  input  logic                           s_axis_tuser,  // progress_undefined
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lrw_pkg::TDATA_W-1:0]    m_axis_tdata,  // mapped[16:0], zero pad
  output logic                           m_axis_tuser,  // mapped_undefined
  // register writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lrw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lrw_pkg::CFG_DAT_W-1:0]  cfg_data_i
);
  import lrw_pkg::*;

  localparam int unsigned DW  = QW + 1;     // signed span max - min
  localparam int unsigned SPW = 2 * DW;     // span product
  localparam int unsigned SW  = SPW - 16;   // floored span product

  cfg_t cfg_q;

  logic          en;
  logic          valid2;
  logic [QW-1:0] v2;
  logic          undef2;

  // stage 3
  logic                  valid3_q;
  logic                  undef3_q;
  logic [QW-1:0]         v3_q;
  logic signed [DW-1:0]  diff;
  logic signed [SPW-1:0] sprod_d, sprod_q;

  // stage 4
  logic                  valid4_q;
  logic                  undef4_q;
  logic [QW-1:0]         mapped_d, mapped_q;
  logic signed [SW-1:0]  scaled;
  logic                  passthru;

  assign en            = !valid4_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_IDENTITY;
      cfg_q.coef_a    <= CW'(65536);
      cfg_q.offset_b  <= '0;
      cfg_q.range_min <= '0;
      cfg_q.range_max <= ONE_Q16;
      cfg_q.shrink    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE:      cfg_q.mode      <= cfg_data_i[2:0];
        REG_COEF_A:    cfg_q.coef_a    <= $signed(cfg_data_i[CW-1:0]);
        REG_OFFSET_B:  cfg_q.offset_b  <= $signed(cfg_data_i[CW-1:0]);
        REG_RANGE_MIN: cfg_q.range_min <= sat_one(cfg_data_i[QW-1:0]);
        REG_RANGE_MAX: cfg_q.range_max <= sat_one(cfg_data_i[QW-1:0]);
        REG_SHRINK:    cfg_q.shrink    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lrw_linear u_linear (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .valid_i    (s_axis_tvalid),
    .progress_i (s_axis_tdata[QW-1:0]),
    .undef_i    (s_axis_tuser),
    .valid_o    (valid2),
    .value_o    (v2),
    .undef_o    (undef2)
  );

  assign diff    = $signed({1'b0, cfg_q.range_max}) - $signed({1'b0, cfg_q.range_min});
  assign sprod_d = diff * $signed({1'b0, v2});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else if (en) begin
      valid3_q <= valid2;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      undef3_q <= undef2;
      v3_q     <= v2;
      sprod_q  <= sprod_d;
      undef4_q <= undef3_q;
      mapped_q <= mapped_d;
    end
  end

  assign passthru = (cfg_q.range_min == '0) && (cfg_q.range_max == ONE_Q16);
  assign scaled   = $signed(sprod_q[SPW-1:16])
                  + $signed({{(SW-QW){1'b0}}, cfg_q.range_min});

  always_comb begin
    mapped_d = v3_q;
    priority if (undef3_q) begin
      mapped_d = '0;
    end else if (passthru) begin
      mapped_d = v3_q;
    end else if (cfg_q.shrink) begin
      mapped_d = scaled[QW-1:0];
    end else if (v3_q < cfg_q.range_min) begin
      mapped_d = cfg_q.range_min;
    end else if (v3_q > cfg_q.range_max) begin
      mapped_d = cfg_q.range_max;
    end
  end

  assign m_axis_tvalid = valid4_q;
  assign m_axis_tdata  = {{(TDATA_W-QW){1'b0}}, mapped_q};
  assign m_axis_tuser  = undef4_q;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for linear_remap_with_wrap_unit
// ----------------------------------------------------------------------------
// a queue of progress samples feeds a clocked stream driver; a clocked monitor
// predicts each accepted sample from a local copy of the registers and checks
// every output transaction against the oldest prediction. a directed sweep of
// the modes and bound corner cases is followed by randomized settings, with
// sender and receiver gaps varied per phase and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import lrw_pkg::*;

  localparam longint Q_ONE = longint'(ONE_Q16);
  localparam logic [2:0] MODE_FOLD_ALIAS = 3'd7;  // codes above fold act as fold
  localparam int PIPE_DEPTH = 4;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [QW-1:0] progress;
    logic          undef;
  } sample_t;

  typedef struct {
    logic [QW-1:0] mapped;
    logic          undef;
  } remap_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;  // progress[16:0], zero pad
  logic                 s_axis_tuser = 1'b0;  // progress_undefined
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;  // mapped[16:0], zero pad
  logic                 m_axis_tuser;  // mapped_undefined
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  linear_remap_with_wrap_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  sample_t progress_feed[$];
  remap_t  predicted_maps[$];
  cfg_t    regs;
  int      bad_count = 0;
  int      send_gap_pct = 0;
  int      take_gap_pct = 0;
  logic    in_accepted = 1'b0;
  logic    hold_go = 1'b0;
  logic    hold_used = 1'b0;
  int      hold_left = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #800000;
    $display("CHECK FAILED");
    $finish;
  end

  // remapped value for one progress sample under the current registers
  function automatic remap_t remap_progress(logic [QW-1:0] progress, logic undef);
    remap_t res;
    longint x, r, v, lo, hi;
    res.mapped = '0;
    res.undef  = undef;
    x = (progress > ONE_Q16) ? Q_ONE : longint'(progress);
    v = x;
    if (!undef && regs.mode != MODE_IDENTITY) begin
      // truncating the q8.32 product is a floor, hence the arithmetic shift
      r = ((longint'($signed(regs.coef_a)) * x) >>> 16) + longint'($signed(regs.offset_b));
      if (r >= 0 && r <= Q_ONE) begin
        v = r;
      end else if (regs.mode == MODE_UNDEF) begin
        res.undef = 1'b1;
      end else if (regs.mode == MODE_CLAMP) begin
        v = (r < 0) ? 0 : Q_ONE;
      end else begin
        v = r & 64'hFFFF;
        if (regs.mode != MODE_WRAP && r[16]) v = Q_ONE - v;
      end
    end
    if (!res.undef) begin
      lo = longint'(regs.range_min);
      hi = longint'(regs.range_max);
      if (!(lo == 0 && hi == Q_ONE)) begin
        if (regs.shrink) begin
          v = lo + (((hi - lo) * v) >>> 16);
        end else if (v < lo) begin
          v = lo;
        end else if (v > hi) begin
          v = hi;
        end
      end
      res.mapped = v[QW-1:0];
    end
    return res;
  endfunction

  // stream driver
  always @(negedge clk_i) begin
    sample_t s;
    if (!s_axis_tvalid || in_accepted) begin
      if (progress_feed.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        s = progress_feed.pop_front();
        s_axis_tdata  <= TDATA_W'(s.progress);
        s_axis_tuser  <= s.undef;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver with one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_used     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  // monitor: predict on input transactions, check on output transactions
  always @(posedge clk_i) begin
    remap_t want;
    in_accepted <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        predicted_maps.push_back(remap_progress(s_axis_tdata[QW-1:0], s_axis_tuser));
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_maps.size() == 0) begin
          if (bad_count < 10)
            $display("unexpected output: mapped=%0d undef=%0b",
                     m_axis_tdata[QW-1:0], m_axis_tuser);
          bad_count++;
        end else begin
          want = predicted_maps.pop_front();
          if (m_axis_tdata[QW-1:0] !== want.mapped || m_axis_tuser !== want.undef) begin
            if (bad_count < 10)
              $display("mismatch: mapped exp=%0d got=%0d  undef exp=%0b got=%0b",
                       want.mapped, m_axis_tdata[QW-1:0], want.undef, m_axis_tuser);
            bad_count++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MODE:      regs.mode = data[2:0];
      REG_COEF_A:    regs.coef_a = data;
      REG_OFFSET_B:  regs.offset_b = data;
      REG_RANGE_MIN: regs.range_min = (data[QW-1:0] > ONE_Q16) ? ONE_Q16 : data[QW-1:0];
      REG_RANGE_MAX: regs.range_max = (data[QW-1:0] > ONE_Q16) ? ONE_Q16 : data[QW-1:0];
      REG_SHRINK:    regs.shrink = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_regs(logic [2:0] mode, logic [CFG_DAT_W-1:0] a, logic [CFG_DAT_W-1:0] b,
                            logic [CFG_DAT_W-1:0] lo, logic [CFG_DAT_W-1:0] hi, logic sh);
    write_reg(REG_MODE, CFG_DAT_W'(mode));
    write_reg(REG_COEF_A, a);
    write_reg(REG_OFFSET_B, b);
    write_reg(REG_RANGE_MIN, lo);
    write_reg(REG_RANGE_MAX, hi);
    write_reg(REG_SHRINK, CFG_DAT_W'(sh));
  endtask

  task automatic feed(int progress, logic undef);
    sample_t s;
    s.progress = QW'(progress);
    s.undef    = undef;
    progress_feed.push_back(s);
  endtask

  // let the pipe empty before touching the registers
  task automatic wait_idle();
    int guard;
    while (progress_feed.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    guard = 0;
    while (predicted_maps.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DAT_W-1:0] pick_coef(int span);
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return CFG_DAT_W'($urandom_range(2 * span) - span);
    if (sel < 85) return CFG_DAT_W'($urandom);
    case ($urandom_range(3))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return CFG_DAT_W'(Q_ONE);
      default: return CFG_DAT_W'(-Q_ONE);
    endcase
  endfunction

  task automatic random_setting();
    int sel;
    logic [CFG_DAT_W-1:0] lo, hi;
    sel = $urandom_range(99);
    if (sel < 40) begin
      lo = '0;
      hi = CFG_DAT_W'(Q_ONE);
    end else if (sel < 80) begin
      lo = CFG_DAT_W'($urandom_range(65536));
      hi = CFG_DAT_W'($urandom_range(65536));
    end else begin
      lo = CFG_DAT_W'($urandom);
      hi = CFG_DAT_W'($urandom);
    end
    write_regs(3'($urandom_range(7)), pick_coef(4 * 65536), pick_coef(2 * 65536),
               lo, hi, 1'($urandom_range(1)));
  endtask

  task automatic random_samples(int count);
    int sel;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 10)
        feed($urandom_range(1) ? 65536 : 0, $urandom_range(7) == 0);
      else if (sel < 25)
        feed($urandom & 32'h1FFFF, $urandom_range(7) == 0);
      else
        feed($urandom_range(65536), $urandom_range(7) == 0);
    end
  endtask

  initial begin
    regs.mode      = MODE_IDENTITY;
    regs.coef_a    = CW'(Q_ONE);
    regs.offset_b  = '0;
    regs.range_min = '0;
    regs.range_max = ONE_Q16;
    regs.shrink    = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: identity, pass-through bounds, input above 1.0
    feed(0, 1'b0);
    feed(65536, 1'b0);
    feed(131071, 1'b0);
    feed(12345, 1'b1);
    wait_idle();

    // slope 2, offset -0.5: both ends leave the unit range
    write_regs(MODE_UNDEF, 24'(131072), 24'(-32768), 24'd0, 24'(65536), 1'b0);
    feed(0, 1'b0);
    feed(65536, 1'b0);
    feed(32768, 1'b0);
    wait_idle();
    write_reg(REG_MODE, CFG_DAT_W'(MODE_CLAMP));
    feed(0, 1'b0);
    feed(65536, 1'b0);
    feed(20000, 1'b0);
    wait_idle();

    // negative results wrap to their fraction
    write_regs(MODE_WRAP, 24'(-196608), 24'd0, 24'd0, 24'(65536), 1'b0);
    feed(0, 1'b0);
    feed(65536, 1'b0);
    feed(21845, 1'b0);
    wait_idle();

    // fold, including a whole odd result that must give 1.0
    write_regs(MODE_FOLD, 24'(196608), 24'd0, 24'd0, 24'(65536), 1'b0);
    feed(65536, 1'b0);
    feed(32768, 1'b0);
    feed(43690, 1'b0);
    wait_idle();

    // extreme coefficients, fold alias code, shrink with min above max
    write_regs(MODE_FOLD_ALIAS, 24'h800000, 24'h7FFFFF, 24'(60000), 24'(10000), 1'b1);
    feed(0, 1'b0);
    feed(65536, 1'b0);
    feed(1, 1'b0);
    wait_idle();

    // clamp with min above max
    write_regs(MODE_IDENTITY, 24'(65536), 24'd0, 24'(50000), 24'(20000), 1'b0);
    feed(10000, 1'b0);
    feed(60000, 1'b0);
    feed(50000, 1'b0);
    wait_idle();

    // bounds written above 1.0 saturate
    write_regs(MODE_IDENTITY, 24'(65536), 24'd0, 24'hFFFFFF, 24'h01FFFF, 1'b1);
    feed(0, 1'b0);
    feed(40000, 1'b0);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct = (phase == 0) ? 18 : (phase == 1) ? 87 : 0;
      take_gap_pct = (phase == 0) ? 87 : (phase == 1) ? 18 : 0;
      for (int n = 0; n < 5; n++) begin
        random_setting();
        random_samples(67);
        if (phase == 2 && n == 0) begin
          @(posedge clk_i);
          hold_go = 1'b1;
        end
        wait_idle();
      end
    end

    if (predicted_maps.size() != 0) begin
      $display("%0d results never arrived", predicted_maps.size());
      bad_count += predicted_maps.size();
    end
    if (bad_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
